// ----- rtl/core/upps_pkg.sv -----
// ----------------------------------------------------------------------------
// upps_pkg
// Shared types and constants for the UDP port packet steering block.
// ----------------------------------------------------------------------------
package upps_pkg;

    localparam logic [15:0] DEFAULT_UDP_PORT = 16'd9000;
    localparam int          QUEUE_COUNT      = 64;
    localparam logic [7:0]  QUEUE_LIMIT      = 8'(QUEUE_COUNT);

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  IP_PROTO_UDP   = 8'd17;
    localparam logic [3:0]  IHL_MIN        = 4'd5;

    localparam logic [6:0]  POS_ETYPE_HI   = 7'd12;
    localparam logic [6:0]  POS_ETYPE_LO   = 7'd13;
    localparam logic [6:0]  POS_IHL        = 7'd14;
    localparam logic [6:0]  POS_PROTO      = 7'd23;
    localparam logic [6:0]  POS_IP_MIN_END = 7'd34;
    localparam logic [6:0]  ETH_HDR_LEN    = 7'd14;
    localparam logic [6:0]  POS_MAX        = 7'd127;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_ADDR_W-1:0] REG_MATCH_PORT  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_BOND_IF     = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_BOUND_QMASK = 2'd2;

    typedef enum logic [1:0] {
        VERDICT_PASS  = 2'd0,
        VERDICT_BOND  = 2'd1,
        VERDICT_STEER = 2'd2
    } verdict_t;

    typedef struct packed {
        logic [15:0] want_port;
        logic [31:0] bond_if;
        logic [63:0] bound_mask;
    } cfg_t;

    typedef struct packed {
        logic       matched;
        logic [7:0] queue;
    } summary_t;

    // packed so that verdict sits in the lowest bits
    typedef struct packed {
        logic [63:0] port_matches;
        logic [63:0] frames_seen;
        logic [5:0]  target_queue;
        logic [31:0] target_interface;
        verdict_t    verdict;
    } result_t;

endpackage

// ----- rtl/core/upps_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// upps_cfg_regs
// Configuration registers: steered port, bond interface, bound queue mask.
// ----------------------------------------------------------------------------
module upps_cfg_regs
    import upps_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    output cfg_t                  cfg
);

    logic [15:0] match_port_reg;
    logic [31:0] bond_if_reg;
    logic [63:0] bound_mask_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_port_reg <= '0;
            bond_if_reg    <= '0;
            bound_mask_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_MATCH_PORT:  match_port_reg <= cfg_wr_data[15:0];
                REG_BOND_IF:     bond_if_reg    <= cfg_wr_data[31:0];
                REG_BOUND_QMASK: bound_mask_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        cfg.want_port  = (match_port_reg != 16'd0) ? match_port_reg : DEFAULT_UDP_PORT;
        cfg.bond_if    = bond_if_reg;
        cfg.bound_mask = bound_mask_reg;
    end

endmodule

// ----- rtl/core/upps_parser.sv -----
// ----------------------------------------------------------------------------
// upps_parser
// Per-byte header capture; registers a match summary on the last byte.
// ----------------------------------------------------------------------------
module upps_parser
    import upps_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  frame_byte,
    input  logic        frame_end,
    input  logic [7:0]  receive_queue,
    input  logic [15:0] want_port,
    output logic        sum_valid,
    output summary_t    sum,
    input  logic        sum_take
);

    logic [6:0]  pos_reg,   pos_next;
    logic [15:0] etype_reg, etype_next;
    logic [3:0]  ihl_reg,   ihl_next;
    logic [7:0]  proto_reg, proto_next;
    logic [15:0] dport_reg, dport_next;
    logic        done_reg,  done_next;
    logic        sum_valid_reg;
    summary_t    sum_reg;

    logic       accept;
    logic [6:0] udp_off;
    logic       udp_zone;
    logic       matched;

    assign s_tready = !sum_valid_reg || sum_take;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        etype_next = etype_reg;
        ihl_next   = ihl_reg;
        proto_next = proto_reg;
        dport_next = dport_reg;
        done_next  = done_reg;

        if (pos_reg == POS_ETYPE_HI) begin
            etype_next[15:8] = frame_byte;
        end else if (pos_reg == POS_ETYPE_LO) begin
            etype_next[7:0] = frame_byte;
        end else if (pos_reg == POS_IHL) begin
            ihl_next = frame_byte[3:0];
        end else if (pos_reg == POS_PROTO) begin
            proto_next = frame_byte;
        end

        udp_off  = ETH_HDR_LEN + {1'b0, ihl_next, 2'b00};
        udp_zone = (ihl_next >= IHL_MIN) && (pos_reg >= POS_IP_MIN_END);

        if (udp_zone) begin
            if (pos_reg == udp_off + 7'd2) begin
                dport_next[15:8] = frame_byte;
            end else if (pos_reg == udp_off + 7'd3) begin
                dport_next[7:0] = frame_byte;
            end else if (pos_reg == udp_off + 7'd7) begin
                done_next = 1'b1;
            end
        end

        // length checks are implied by done_next
        matched = (etype_next == ETHERTYPE_IPV4) && (proto_next == IP_PROTO_UDP) &&
                  (ihl_next >= IHL_MIN) && done_next && (dport_next == want_port);

        pos_next = (pos_reg < POS_MAX) ? pos_reg + 7'd1 : pos_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            etype_reg <= '0;
            ihl_reg   <= '0;
            proto_reg <= '0;
            dport_reg <= '0;
            done_reg  <= 1'b0;
        end else if (accept) begin
            if (frame_end) begin
                pos_reg   <= '0;
                etype_reg <= '0;
                ihl_reg   <= '0;
                proto_reg <= '0;
                dport_reg <= '0;
                done_reg  <= 1'b0;
            end else begin
                pos_reg   <= pos_next;
                etype_reg <= etype_next;
                ihl_reg   <= ihl_next;
                proto_reg <= proto_next;
                dport_reg <= dport_next;
                done_reg  <= done_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_valid_reg <= 1'b0;
        end else if (accept && frame_end) begin
            sum_valid_reg <= 1'b1;
        end else if (sum_take) begin
            sum_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && frame_end) begin
            sum_reg.matched <= matched;
            sum_reg.queue   <= receive_queue;
        end
    end

    assign sum_valid = sum_valid_reg;
    assign sum       = sum_reg;

endmodule

// ----- rtl/core/upps_verdict.sv -----
// ----------------------------------------------------------------------------
// upps_verdict
// Steering decision, frame/match counters and the result register.
// ----------------------------------------------------------------------------
module upps_verdict
    import upps_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  cfg_t     cfg,
    input  logic     sum_valid,
    input  summary_t sum,
    output logic     sum_take,
    output logic     m_tvalid,
    input  logic     m_tready,
    output result_t  result
);

    logic [63:0] seen_reg,  seen_next;
    logic [63:0] match_reg, match_next;
    logic        m_valid_reg;
    result_t     result_reg, result_next;
    logic        out_ready;
    logic        steer;

    assign out_ready = !m_valid_reg || m_tready;
    assign sum_take  = sum_valid && out_ready;

    always_comb begin
        seen_next  = seen_reg + 64'd1;
        match_next = match_reg + {63'd0, sum.matched};
        steer      = sum.matched && (sum.queue < QUEUE_LIMIT) &&
                     cfg.bound_mask[sum.queue[5:0]];

        result_next.frames_seen      = seen_next;
        result_next.port_matches     = match_next;
        result_next.target_interface = '0;
        result_next.target_queue     = '0;
        if (steer) begin
            result_next.verdict      = VERDICT_STEER;
            result_next.target_queue = sum.queue[5:0];
        end else if (cfg.bond_if != 32'd0) begin
            result_next.verdict          = VERDICT_BOND;
            result_next.target_interface = cfg.bond_if;
        end else begin
            result_next.verdict = VERDICT_PASS;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg    <= '0;
            match_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else if (sum_take) begin
            seen_reg    <= seen_next;
            match_reg   <= match_next;
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (sum_take) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign result   = result_reg;

endmodule

// ----- rtl/core/udp_port_packet_steering.sv -----
// ----------------------------------------------------------------------------
// udp_port_packet_steering
// Steers UDP frames by destination port to bound socket queues.
// ----------------------------------------------------------------------------
// The parser registers a match summary on the last byte; upps_verdict then registers
//   the verdict. Throughput: one byte request per cycle unless m_tready stalls the verdict;
//   capture and verdict are one register stage each, so frames stream without gaps.
// Reset: synchronous aresetn clears config, parser state, counters and m_tvalid.
module udp_port_packet_steering
    import upps_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] frame_byte
    input  logic                  s_tlast,   // frame_end
    input  logic [7:0]            s_tuser,   // [7:0] receive_queue
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [167:0]          m_tdata    // [1:0] verdict, [33:2] target_interface,
                                             // [39:34] target_queue, [103:40] frames_seen,
                                             // [167:104] port_matches
);

    cfg_t     cfg;
    logic     sum_valid;
    logic     sum_take;
    summary_t sum;
    result_t  result;

    upps_cfg_regs u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    upps_parser u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .frame_byte    (s_tdata),
        .frame_end     (s_tlast),
        .receive_queue (s_tuser),
        .want_port     (cfg.want_port),
        .sum_valid     (sum_valid),
        .sum           (sum),
        .sum_take      (sum_take)
    );

    upps_verdict u_verdict (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .sum_valid (sum_valid),
        .sum       (sum),
        .sum_take  (sum_take),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .result    (result)
    );

    assign m_tdata = result;

endmodule

// ----- rtl/core/upps_checker.sv -----
// ----------------------------------------------------------------------------
// upps_checker
// Port-level checks on the steering verdict stream.
// ----------------------------------------------------------------------------
module upps_checker
    import upps_pkg::*;
(
    input logic         aclk,
    input logic         aresetn,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [167:0] m_tdata
);

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_verdict_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[1:0] != 2'd3)
        else $error("illegal verdict code");

    a_queue_only_on_steer: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] != VERDICT_STEER) |-> m_tdata[39:34] == 6'd0)
        else $error("target_queue set without steer");

    a_iface_only_on_bond: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] != VERDICT_BOND) |-> m_tdata[33:2] == 32'd0)
        else $error("target_interface set without bond redirect");

endmodule

bind udp_port_packet_steering upps_checker u_upps_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- dv/upps_verdict_checker.sv -----
// ----------------------------------------------------------------------------
// upps_verdict_checker
// Watches the config port and both streams of udp_port_packet_steering,
// predicts one verdict per frame from the byte stream and compares every
// returned verdict field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module upps_verdict_checker
    import upps_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] frame_byte
    input  logic                  s_tlast,   // frame_end
    input  logic [7:0]            s_tuser,   // [7:0] receive_queue
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [167:0]          m_tdata,   // [1:0] verdict, [33:2] target_interface,
                                             // [39:34] target_queue, [103:40] frames_seen,
                                             // [167:104] port_matches
    output int                    mismatches,
    output int                    verdicts_owed
);

    logic [15:0] port_cfg;
    logic [31:0] bond_cfg;
    logic [63:0] bound_cfg;

    logic [6:0]  byte_pos;
    logic [15:0] etype;
    logic [3:0]  ihl;
    logic [7:0]  proto;
    logic [15:0] dst_port;
    logic        udp_seen;
    logic [63:0] seen_cnt;
    logic [63:0] match_cnt;

    result_t     verdict_q[$];
    int          err_cnt = 0;

    function automatic int field_diff(string name, logic [63:0] exp, logic [63:0] act);
        if (exp !== act) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp, act);
            return 1;
        end
        return 0;
    endfunction

    task automatic clear_frame;
        byte_pos = '0;
        etype    = '0;
        ihl      = '0;
        proto    = '0;
        dst_port = '0;
        udp_seen = 1'b0;
    endtask

    task automatic take_byte(input logic [7:0] b, input logic last, input logic [7:0] q);
        int          udp_at;
        logic [15:0] want;
        logic        hit;
        result_t     r;
        if (byte_pos == POS_ETYPE_HI) begin
            etype[15:8] = b;
        end else if (byte_pos == POS_ETYPE_LO) begin
            etype[7:0] = b;
        end else if (byte_pos == POS_IHL) begin
            ihl = b[3:0];
        end else if (byte_pos == POS_PROTO) begin
            proto = b;
        end
        if (ihl >= IHL_MIN && byte_pos >= POS_IP_MIN_END) begin
            udp_at = int'(ETH_HDR_LEN) + 4 * int'(ihl);
            if (int'(byte_pos) == udp_at + 2) begin
                dst_port[15:8] = b;
            end else if (int'(byte_pos) == udp_at + 3) begin
                dst_port[7:0] = b;
            end else if (int'(byte_pos) == udp_at + 7) begin
                udp_seen = 1'b1;
            end
        end
        if (!last) begin
            if (byte_pos < POS_MAX) begin
                byte_pos = byte_pos + 7'd1;
            end
            return;
        end
        want     = (port_cfg != '0) ? port_cfg : DEFAULT_UDP_PORT;
        seen_cnt = seen_cnt + 64'd1;
        // frame length pos+1 must cover the minimal IPv4 header
        hit = (byte_pos >= POS_IP_MIN_END - 7'd1) && etype == ETHERTYPE_IPV4 &&
              proto == IP_PROTO_UDP && ihl >= IHL_MIN && udp_seen && dst_port == want;
        if (hit) begin
            match_cnt = match_cnt + 64'd1;
        end
        r = '0;
        if (hit && q < QUEUE_LIMIT && bound_cfg[q[5:0]]) begin
            r.verdict      = VERDICT_STEER;
            r.target_queue = q[5:0];
        end else if (bond_cfg != '0) begin
            r.verdict          = VERDICT_BOND;
            r.target_interface = bond_cfg;
        end else begin
            r.verdict = VERDICT_PASS;
        end
        r.frames_seen  = seen_cnt;
        r.port_matches = match_cnt;
        verdict_q.push_back(r);
        clear_frame();
    endtask

    always @(posedge aclk) begin : watch
        result_t exp_r;
        result_t got_r;
        if (!aresetn) begin
            port_cfg  = '0;
            bond_cfg  = '0;
            bound_cfg = '0;
            seen_cnt  = '0;
            match_cnt = '0;
            clear_frame();
            verdict_q.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_MATCH_PORT:  port_cfg  = cfg_wr_data[15:0];
                    REG_BOND_IF:     bond_cfg  = cfg_wr_data[31:0];
                    REG_BOUND_QMASK: bound_cfg = cfg_wr_data;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got_r = result_t'(m_tdata);
                if (verdict_q.size() == 0) begin
                    $error("verdict returned with no frame outstanding");
                    err_cnt++;
                end else begin
                    exp_r = verdict_q.pop_front();
                    err_cnt += field_diff("verdict", 64'(exp_r.verdict), 64'(got_r.verdict));
                    err_cnt += field_diff("target_interface", 64'(exp_r.target_interface),
                                          64'(got_r.target_interface));
                    err_cnt += field_diff("target_queue", 64'(exp_r.target_queue),
                                          64'(got_r.target_queue));
                    err_cnt += field_diff("frames_seen", exp_r.frames_seen, got_r.frames_seen);
                    err_cnt += field_diff("port_matches", exp_r.port_matches,
                                          got_r.port_matches);
                end
            end
            if (s_tvalid && s_tready) begin
                take_byte(s_tdata, s_tlast, s_tuser);
            end
        end
        mismatches    <= err_cnt;
        verdicts_owed <= verdict_q.size();
    end

endmodule

// ----- dv/tb_udp_port_packet_steering.sv -----
// ----------------------------------------------------------------------------
// tb_udp_port_packet_steering
// Drives Ethernet frames byte by byte into udp_port_packet_steering: directed
// header corner cases first, then random well-formed UDP frames mixed with
// broken, truncated and noise frames over several register settings, with
// random idle gaps on both streams. A separate checker judges the verdicts.
// ----------------------------------------------------------------------------
module tb_udp_port_packet_steering;
    import upps_pkg::*;

    localparam int ITEMS      = 1650;
    localparam int NUM_PHASES = 6;
    localparam int MIN_FRAMES = 12;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr    = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata     = '0;   // [7:0] frame_byte
    logic                  s_tlast     = 1'b0; // frame_end
    logic [7:0]            s_tuser     = '0;   // [7:0] receive_queue
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic [167:0]          m_tdata;            // [1:0] verdict, [33:2] target_interface,
                                               // [39:34] target_queue, [103:40] frames_seen,
                                               // [167:104] port_matches
    int                    mismatches;
    int                    verdicts_owed;

    logic [7:0]  frame_buf[$];
    int          tx_max     = 0;
    int          rx_max     = 0;
    int          rx_hold    = 0;
    int          bytes_sent = 0;
    int          frames_sent = 0;
    logic [15:0] cur_want   = DEFAULT_UDP_PORT;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    udp_port_packet_steering i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    upps_verdict_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wr_data   (cfg_wr_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .mismatches    (mismatches),
        .verdicts_owed (verdicts_owed)
    );

    // result side backpressure: one stall draw per accepted verdict
    always @(posedge aclk) begin : rx_side
        int nxt;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_hold  <= 0;
        end else if (m_tvalid && m_tready) begin
            if ($urandom_range(0, 7) == 0) begin
                rx_max = ($urandom_range(0, 2) == 0) ? 0 : 18;
            end
            nxt = $urandom_range(0, rx_max);
            m_tready <= (nxt == 0);
            rx_hold  <= nxt;
        end else if (rx_hold != 0) begin
            m_tready <= (rx_hold == 1);
            rx_hold  <= rx_hold - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last, input logic [7:0] user);
        int gap;
        gap = $urandom_range(0, tx_max);
        repeat (gap) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        s_tuser  <= user;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [7:0] queue);
        int n;
        n = frame_buf.size();
        tx_max = ($urandom_range(0, 3) == 0) ? 0 : 18;
        for (int i = 0; i < n; i++) begin
            send_byte(frame_buf[i], i == n - 1, (i == n - 1) ? queue : 8'($urandom));
        end
        frames_sent++;
    endtask

    // Ethernet + IPv4 + UDP layout; IHL below 5 keeps a 20-byte header
    task automatic make_frame(input logic [3:0] ihl, input logic [15:0] etype,
                              input logic [7:0] proto, input logic [15:0] dport,
                              input int extra);
        int udp_at;
        udp_at = 14 + 4 * ((ihl < IHL_MIN) ? 5 : int'(ihl));
        frame_buf.delete();
        for (int i = 0; i < udp_at + 8 + extra; i++) begin
            frame_buf.push_back(8'($urandom));
        end
        frame_buf[12]         = etype[15:8];
        frame_buf[13]         = etype[7:0];
        frame_buf[14]         = {4'($urandom), ihl};
        frame_buf[23]         = proto;
        frame_buf[udp_at + 2] = dport[15:8];
        frame_buf[udp_at + 3] = dport[7:0];
    endtask

    task automatic cut_frame(input int len);
        while (frame_buf.size() > len) begin
            void'(frame_buf.pop_back());
        end
    endtask

    task automatic make_noise(input int len);
        frame_buf.delete();
        for (int i = 0; i < len; i++) begin
            frame_buf.push_back(8'($urandom));
        end
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (verdicts_owed != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_config(input logic [15:0] port, input logic [31:0] bond,
                              input logic [63:0] mask);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= REG_MATCH_PORT;
        cfg_wr_data <= 64'(port);
        @(posedge aclk);
        cfg_addr    <= REG_BOND_IF;
        cfg_wr_data <= 64'(bond);
        @(posedge aclk);
        cfg_addr    <= REG_BOUND_QMASK;
        cfg_wr_data <= mask;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        cur_want = (port != '0) ? port : DEFAULT_UDP_PORT;
    endtask

    function automatic logic [15:0] pick_port;
        case ($urandom_range(0, 5))
            0, 1, 2: return cur_want;
            3:       return DEFAULT_UDP_PORT;
            4:       return cur_want ^ (16'h1 << $urandom_range(0, 15));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_frame;
        int          kind;
        logic [3:0]  ihl;
        logic [7:0]  queue;
        int          extra;
        kind  = $urandom_range(0, 9);
        ihl   = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(5, 15)) : IHL_MIN;
        extra = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 90) : $urandom_range(0, 10);
        queue = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 63));
        make_frame(ihl, ETHERTYPE_IPV4, IP_PROTO_UDP, pick_port(), extra);
        case (kind)
            6: begin
                case ($urandom_range(0, 2))
                    0: frame_buf[12] = frame_buf[12] ^ (8'h1 << $urandom_range(0, 7));
                    1: frame_buf[23] = 8'($urandom);
                    default: frame_buf[14] = {frame_buf[14][7:4], 4'($urandom_range(0, 4))};
                endcase
            end
            7: cut_frame($urandom_range(1, frame_buf.size() - 1));
            8: make_noise($urandom_range(1, 40));
            default: ;
        endcase
        send_frame(queue);
    endtask

    initial begin : stimulus
        int          base;
        int          fbase;
        logic [15:0] port;
        logic [31:0] bond;
        logic [63:0] mask;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: default port, queues 0 and 63 bound, no bond
        set_config(16'd0, 32'd0, 64'h8000_0000_0000_0001);
        frame_buf = {8'hFF};
        send_frame(8'hFF);
        make_noise(13);
        send_frame(8'd0);
        make_frame(IHL_MIN, ETHERTYPE_IPV4, IP_PROTO_UDP, DEFAULT_UDP_PORT, 0);
        frame_buf[0] = 8'h00;
        send_frame(8'd0);
        make_frame(IHL_MIN, ETHERTYPE_IPV4, IP_PROTO_UDP, DEFAULT_UDP_PORT, 4);
        send_frame(8'd63);
        make_frame(IHL_MIN, ETHERTYPE_IPV4, IP_PROTO_UDP, DEFAULT_UDP_PORT, 0);
        send_frame(8'd64);
        make_frame(IHL_MIN, ETHERTYPE_IPV4, IP_PROTO_UDP, DEFAULT_UDP_PORT, 0);
        send_frame(8'd5);
        make_frame(IHL_MIN, ETHERTYPE_IPV4, IP_PROTO_UDP, DEFAULT_UDP_PORT, 0);
        send_frame(8'd255);
        make_frame(IHL_MIN, 16'h0801, IP_PROTO_UDP, DEFAULT_UDP_PORT, 0);
        send_frame(8'd0);
        make_frame(IHL_MIN, ETHERTYPE_IPV4, 8'd6, DEFAULT_UDP_PORT, 0);
        send_frame(8'd0);
        make_frame(4'd4, ETHERTYPE_IPV4, IP_PROTO_UDP, DEFAULT_UDP_PORT, 0);
        send_frame(8'd0);
        make_frame(4'd15, ETHERTYPE_IPV4, IP_PROTO_UDP, DEFAULT_UDP_PORT, 3);
        send_frame(8'd0);
        make_frame(IHL_MIN, ETHERTYPE_IPV4, IP_PROTO_UDP, DEFAULT_UDP_PORT, 0);
        cut_frame(41);
        send_frame(8'd0);
        make_frame(IHL_MIN, ETHERTYPE_IPV4, IP_PROTO_UDP, DEFAULT_UDP_PORT, 0);
        cut_frame(33);
        send_frame(8'd0);
        make_frame(IHL_MIN, ETHERTYPE_IPV4, IP_PROTO_UDP, DEFAULT_UDP_PORT, 98);
        send_frame(8'd63);
        make_frame(IHL_MIN, ETHERTYPE_IPV4, IP_PROTO_UDP, DEFAULT_UDP_PORT + 16'd1, 0);
        send_frame(8'd0);
        drain();

        // bond set, nothing bound, top port value
        set_config(16'hFFFF, 32'hFFFF_FFFF, 64'd0);
        make_frame(IHL_MIN, ETHERTYPE_IPV4, IP_PROTO_UDP, 16'hFFFF, 0);
        send_frame(8'd0);
        make_frame(IHL_MIN, ETHERTYPE_IPV4, IP_PROTO_UDP, DEFAULT_UDP_PORT, 0);
        send_frame(8'd1);
        drain();

        // random phases share what is left of the byte budget
        base  = bytes_sent;
        fbase = frames_sent;
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph == 0) begin
                port = 16'hFFFF;
                bond = 32'hFFFF_FFFF;
                mask = '1;
            end else if (ph == 1) begin
                port = 16'd1;
                bond = 32'd0;
                mask = '1;
            end else begin
                case ($urandom_range(0, 3))
                    0:       port = 16'd0;
                    1:       port = DEFAULT_UDP_PORT;
                    default: port = 16'($urandom);
                endcase
                case ($urandom_range(0, 2))
                    0:       bond = 32'd0;
                    1:       bond = 32'd1;
                    default: bond = $urandom;
                endcase
                case ($urandom_range(0, 3))
                    0:       mask = 64'd0;
                    1:       mask = 64'd1 << $urandom_range(0, 63);
                    default: mask = {$urandom, $urandom};
                endcase
            end
            set_config(port, bond, mask);
            while (bytes_sent - base < (ph + 1) * (ITEMS - base) / NUM_PHASES ||
                   frames_sent - fbase < (ph + 1) * MIN_FRAMES / NUM_PHASES) begin
                random_frame();
            end
            drain();
        end

        repeat (8) @(posedge aclk);
        if (mismatches == 0 && verdicts_owed == 0) begin
            $display("tb_udp_port_packet_steering: clean");
        end else begin
            $display("tb_udp_port_packet_steering: errors");
        end
        $finish;
    end

    initial begin : watchdog
        #(20 * 600000);
        $display("tb_udp_port_packet_steering: errors");
        $finish;
    end

endmodule
